[sv/dtr_pkg.sv]
`default_nettype none
package dtr_pkg;

    localparam logic [1:0] ACT_ADVANCE = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_WRITE   = 2'd2;

    localparam logic [1:0] REG_DIV  = 2'd0;
    localparam logic [1:0] REG_CNT  = 2'd1;
    localparam logic [1:0] REG_MOD  = 2'd2;
    localparam logic [1:0] REG_CTRL = 2'd3;

    localparam logic [7:0] CTRL_READ_ONES = 8'hF8;

    localparam logic [2:0] AGE_IRQ    = 3'd4;
    localparam logic [2:0] AGE_RELOAD = 3'd5;
    localparam logic [2:0] AGE_DONE   = 3'd6;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] register_select;
        logic [7:0] write_data;
        logic [7:0] tick_count;
    } t_item;

    // enable in ctrl[2], tap select in ctrl[1:0]: bit 9, 3, 5 or 7
    function automatic logic gated_bit(input logic [15:0] div, input logic [2:0] ctrl);
        logic b;
        case (ctrl[1:0])
            2'd0:    b = div[9];
            2'd1:    b = div[3];
            2'd2:    b = div[5];
            default: b = div[7];
        endcase
        return b & ctrl[2];
    endfunction

endpackage
`default_nettype wire

[sv/dtr_if.sv]
`default_nettype none
interface dtr_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [1:0] register_select;
    logic [7:0] write_data;
    logic [7:0] tick_count;

    modport source (output valid, action, register_select, write_data, tick_count,
                    input ready);
    modport sink   (input valid, action, register_select, write_data, tick_count,
                    output ready);
endinterface

interface dtr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       timer_interrupt;

    modport source (output valid, read_data, timer_interrupt, input ready);
    modport sink   (input valid, read_data, timer_interrupt, output ready);
endinterface
`default_nettype wire

[sv/dtr_in_stage.sv]
`default_nettype none
module dtr_in_stage
    import dtr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    input  wire logic  i_take,
    output logic       o_valid,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

[sv/dtr_core.sv]
`default_nettype none
module dtr_core
    import dtr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_take,
    output logic       o_valid,
    input  wire logic  i_ready,
    output logic [7:0] o_read_data,
    output logic       o_timer_interrupt
);

    logic [15:0] r_div, n_div;
    logic [7:0]  r_cnt, n_cnt;
    logic [7:0]  r_mod, n_mod;
    logic [2:0]  r_ctrl, n_ctrl;
    logic        r_last, n_last;
    logic        r_pend, n_pend;
    logic [2:0]  r_age, n_age;

    logic        r_out_valid;
    logic [7:0]  r_rd, n_rd;
    logic        r_irq, n_irq;

    logic        s_bit;

    assign o_take            = i_valid && (!r_out_valid || i_ready);
    assign o_valid           = r_out_valid;
    assign o_read_data       = r_rd;
    assign o_timer_interrupt = r_irq;

    always_comb begin
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_mod  = r_mod;
        n_ctrl = r_ctrl;
        n_last = r_last;
        n_pend = r_pend;
        n_age  = r_age;
        n_rd   = 8'd0;
        n_irq  = 1'b0;
        s_bit  = 1'b0;

        case (i_item.action)
            ACT_ADVANCE: begin
                n_div = r_div + {8'd0, i_item.tick_count};
                s_bit = gated_bit(n_div, r_ctrl);
                if (!s_bit && r_last) begin
                    n_cnt = r_cnt + 8'd1;
                    if (n_cnt == 8'd0) begin
                        n_pend = 1'b1;
                        n_age  = 3'd0;
                    end
                end
                n_last = s_bit;
                if (n_pend) begin
                    n_age = n_age + 3'd1;
                    if (n_age == AGE_IRQ) begin
                        n_irq = 1'b1;
                    end
                    if (n_age == AGE_RELOAD) begin
                        n_cnt = r_mod;
                    end
                    if (n_age == AGE_DONE) begin
                        n_cnt  = r_mod;
                        n_pend = 1'b0;
                        n_age  = 3'd0;
                    end
                end
            end
            ACT_READ: begin
                case (i_item.register_select)
                    REG_DIV: n_rd = r_div[15:8];
                    REG_CNT: n_rd = r_cnt;
                    REG_MOD: n_rd = r_mod;
                    default: n_rd = CTRL_READ_ONES | {5'd0, r_ctrl};
                endcase
            end
            ACT_WRITE: begin
                case (i_item.register_select)
                    REG_DIV: begin
                        // cleared divider gates low: a high last bit is a falling edge
                        n_div  = 16'd0;
                        n_last = 1'b0;
                        if (r_last) begin
                            n_cnt = r_cnt + 8'd1;
                            if (n_cnt == 8'd0) begin
                                n_pend = 1'b1;
                                n_age  = 3'd0;
                            end
                        end
                    end
                    REG_CNT: begin
                        if (r_age < AGE_RELOAD) begin
                            n_cnt  = i_item.write_data;
                            n_pend = 1'b0;
                            n_age  = 3'd0;
                        end
                    end
                    REG_MOD: n_mod = i_item.write_data;
                    default: n_ctrl = i_item.write_data[2:0];
                endcase
            end
            default: begin
                n_rd = 8'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div       <= 16'd0;
            r_cnt       <= 8'd0;
            r_mod       <= 8'd0;
            r_ctrl      <= 3'd0;
            r_last      <= 1'b0;
            r_pend      <= 1'b0;
            r_age       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                r_div  <= n_div;
                r_cnt  <= n_cnt;
                r_mod  <= n_mod;
                r_ctrl <= n_ctrl;
                r_last <= n_last;
                r_pend <= n_pend;
                r_age  <= n_age;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_rd  <= n_rd;
            r_irq <= n_irq;
        end
    end

endmodule
`default_nettype wire

[sv/divider_timer_with_reload_top.sv]
// channel  dir  handshake     payload
// i_in     in   valid/ready   action, register_select, write_data, tick_count
// o_out    out  valid/ready   read_data, timer_interrupt
//
// From input transfer to result an item passes the input register, then the
// state update and result register. One item per cycle sustained while the
// output is not stalled; the timer state is updated as an item leaves the input register.
// Synchronous active-low reset clears all timer state and both valid flags.
// A stalled output holds its result; the input register still takes one
// more item, then input ready drops until the output drains.
`default_nettype none
module divider_timer_with_reload_top
    import dtr_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtr_in_if.sink     i_in,
    dtr_out_if.source  o_out
);

    t_item s_in_item;
    t_item s_st_item;
    logic  s_st_valid;
    logic  s_take;
    logic  s_in_ready;
    logic  s_out_valid;
    logic  [7:0] s_rd;
    logic  s_irq;

    assign s_in_item.action          = i_in.action;
    assign s_in_item.register_select = i_in.register_select;
    assign s_in_item.write_data      = i_in.write_data;
    assign s_in_item.tick_count      = i_in.tick_count;
    assign i_in.ready                = s_in_ready;

    assign o_out.valid           = s_out_valid;
    assign o_out.read_data       = s_rd;
    assign o_out.timer_interrupt = s_irq;

    dtr_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (s_in_ready),
        .i_item  (s_in_item),
        .i_take  (s_take),
        .o_valid (s_st_valid),
        .o_item  (s_st_item)
    );

    dtr_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_st_valid),
        .i_item            (s_st_item),
        .o_take            (s_take),
        .o_valid           (s_out_valid),
        .i_ready           (o_out.ready),
        .o_read_data       (s_rd),
        .o_timer_interrupt (s_irq)
    );

endmodule
`default_nettype wire

[sv/dtr_checker.sv]
`default_nettype none
module dtr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_read_data,
    input wire logic       i_timer_interrupt
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // interrupt only comes from an advance, which reads as zero
    a_irq_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_timer_interrupt |-> i_read_data == 8'd0)
        else $error("interrupt with read data");

    // age 4 is followed by age 5 at the next advance: no back-to-back pulses
    a_irq_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_timer_interrupt
        |=> !(i_out_valid && i_timer_interrupt))
        else $error("interrupt on consecutive results");

endmodule

bind divider_timer_with_reload_top dtr_checker u_dtr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_read_data       (o_out.read_data),
    .i_timer_interrupt (o_out.timer_interrupt)
);
`default_nettype wire

[test/divider_timer_with_reload_top_tb.sv]
`timescale 1ns / 1ps
module divider_timer_with_reload_top_tb;
    import dtr_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         N_RANDOM   = 1300;
    localparam int         STALL_LEN  = 80;
    localparam int         WDOG_LIMIT = 4000;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_interrupt;
    } t_timer_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dtr_in_if  in_ch ();
    dtr_out_if out_ch ();

    divider_timer_with_reload_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    t_item         pending_items[$];
    t_timer_result exp_results[$];
    int            total_items = 0;
    int            tx_sent = 0;
    int            rx_in_count = 0;
    int            rx_out_count = 0;
    int            errors = 0;
    int            stall_left = 0;
    bit            stall_done = 1'b0;
    int            idle_cycles = 0;

    // timer model state
    logic [15:0] tm_div;
    logic [7:0]  tm_cnt;
    logic [7:0]  tm_mod;
    logic [2:0]  tm_ctrl;
    logic        tm_last_tap;
    logic        tm_ovf_pend;
    logic [2:0]  tm_ovf_age;

    int unsigned tap_pos [4] = '{9, 3, 5, 7};

    // divider load samples the gated tap; falling edge bumps the counter
    function automatic void load_tm_divider(input logic [15:0] value);
        logic tap;
        tm_div = value;
        tap = tm_div[tap_pos[tm_ctrl[1:0]]] & tm_ctrl[2];
        if (!tap && tm_last_tap) begin
            tm_cnt = tm_cnt + 8'd1;
            if (tm_cnt == 8'd0) begin
                tm_ovf_pend = 1'b1;
                tm_ovf_age  = 3'd0;
            end
        end
        tm_last_tap = tap;
    endfunction

    function automatic t_timer_result predict_timer(input t_item it);
        t_timer_result res;
        res = '0;
        case (it.action)
            ACT_ADVANCE: begin
                load_tm_divider(tm_div + {8'd0, it.tick_count});
                if (tm_ovf_pend) begin
                    tm_ovf_age = tm_ovf_age + 3'd1;
                    if (tm_ovf_age == AGE_IRQ)
                        res.timer_interrupt = 1'b1;
                    if (tm_ovf_age == AGE_RELOAD)
                        tm_cnt = tm_mod;
                    if (tm_ovf_age == AGE_DONE) begin
                        tm_cnt      = tm_mod;
                        tm_ovf_pend = 1'b0;
                        tm_ovf_age  = 3'd0;
                    end
                end
            end
            ACT_READ: begin
                case (it.register_select)
                    REG_DIV:  res.read_data = tm_div[15:8];
                    REG_CNT:  res.read_data = tm_cnt;
                    REG_MOD:  res.read_data = tm_mod;
                    default:  res.read_data = CTRL_READ_ONES | {5'd0, tm_ctrl};
                endcase
            end
            ACT_WRITE: begin
                case (it.register_select)
                    REG_DIV: load_tm_divider(16'd0);
                    REG_CNT: begin
                        // counter write is dropped once reload has started
                        if (tm_ovf_age < AGE_RELOAD) begin
                            tm_cnt      = it.write_data;
                            tm_ovf_pend = 1'b0;
                            tm_ovf_age  = 3'd0;
                        end
                    end
                    REG_MOD: tm_mod = it.write_data;
                    default: tm_ctrl = it.write_data[2:0];
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic int idle_pct(input int done_cnt, input bit receiver);
        if (done_cnt < total_items / 3)
            return receiver ? 83 : 36;
        else if (done_cnt < 2 * total_items / 3)
            return receiver ? 36 : 83;
        return 0;
    endfunction

    function automatic void add_item(input logic [1:0] act, input logic [1:0] sel,
                                     input logic [7:0] data, input logic [7:0] ticks);
        t_item it;
        it.action          = act;
        it.register_select = sel;
        it.write_data      = data;
        it.tick_count      = ticks;
        pending_items.push_back(it);
    endfunction

    function automatic void add_noise_item();
        logic [1:0] act;
        act = ($urandom_range(0, 99) < 4) ? ACT_UNUSED : 2'($urandom_range(0, 2));
        add_item(act, 2'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // usually enable the timer, preload the counter near wrap, then mostly advances
    function automatic void add_overflow_run();
        logic [7:0] ctrl_byte;
        logic [7:0] half_period;
        int         len;
        int         r;
        ctrl_byte = 8'($urandom);
        if ($urandom_range(0, 99) < 90)
            ctrl_byte[2] = 1'b1;
        half_period = (ctrl_byte[1:0] == 2'd0) ? 8'hFF
                                               : 8'(1 << tap_pos[ctrl_byte[1:0]]);
        add_item(ACT_WRITE, REG_CTRL, ctrl_byte, 8'($urandom));
        add_item(ACT_WRITE, REG_MOD, 8'($urandom), 8'($urandom));
        add_item(ACT_WRITE, REG_CNT, 8'($urandom_range(8'hFA, 8'hFF)), 8'($urandom));
        len = $urandom_range(12, 40);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                add_item(ACT_ADVANCE, 2'($urandom), 8'($urandom),
                         $urandom_range(0, 1) ? 8'($urandom) : half_period);
            else if (r < 75)
                add_item(ACT_READ, 2'($urandom), 8'($urandom), 8'($urandom));
            else if (r < 85)
                add_item(ACT_WRITE, REG_CNT, 8'($urandom), 8'($urandom));
            else if (r < 92)
                add_item(ACT_WRITE, REG_DIV, 8'($urandom), 8'($urandom));
            else if (r < 96)
                add_item(ACT_WRITE, REG_MOD, 8'($urandom), 8'($urandom));
            else
                add_item(ACT_WRITE, REG_CTRL, 8'($urandom) | 8'h04, 8'($urandom));
        end
    endfunction

    // sender
    always @(posedge i_clk) begin : drv_proc
        t_item it;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct(tx_sent, 1'b0)) begin
                it = pending_items.pop_front();
                in_ch.valid           <= 1'b1;
                in_ch.action          <= it.action;
                in_ch.register_select <= it.register_select;
                in_ch.write_data      <= it.write_data;
                in_ch.tick_count      <= it.tick_count;
                tx_sent++;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver, predictor and checker
    always @(posedge i_clk) begin : mon_proc
        t_item         it;
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            tm_div      = '0;
            tm_cnt      = '0;
            tm_mod      = '0;
            tm_ctrl     = '0;
            tm_last_tap = 1'b0;
            tm_ovf_pend = 1'b0;
            tm_ovf_age  = '0;
        end else begin
            // check before predicting so a result in the same cycle as its input transfer is caught
            if (out_ch.valid && out_ch.ready) begin
                got.read_data       = out_ch.read_data;
                got.timer_interrupt = out_ch.timer_interrupt;
                rx_out_count++;
                if (exp_results.size() == 0) begin
                    $display("%0t: result with no transfer pending: read_data %02h irq %0b",
                             $time, got.read_data, got.timer_interrupt);
                    errors++;
                end else begin
                    want = exp_results.pop_front();
                    if (got.read_data !== want.read_data) begin
                        $display("%0t: read_data mismatch expected %02h actual %02h",
                                 $time, want.read_data, got.read_data);
                        errors++;
                    end
                    if (got.timer_interrupt !== want.timer_interrupt) begin
                        $display("%0t: timer_interrupt mismatch expected %0b actual %0b",
                                 $time, want.timer_interrupt, got.timer_interrupt);
                        errors++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                it.action          = in_ch.action;
                it.register_select = in_ch.register_select;
                it.write_data      = in_ch.write_data;
                it.tick_count      = in_ch.tick_count;
                exp_results.push_back(predict_timer(it));
                rx_in_count++;
            end
            // one long hold-off early in the unthrottled phase to back up the pipe
            if (!stall_done && rx_out_count >= 2 * total_items / 3 + 10) begin
                stall_done = 1'b1;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= idle_pct(rx_out_count, 1'b1));
            end
        end
    end

    always @(posedge i_clk) begin : wdog_proc
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WDOG_LIMIT);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid           = 1'b0;
        in_ch.action          = ACT_ADVANCE;
        in_ch.register_select = REG_DIV;
        in_ch.write_data      = 8'd0;
        in_ch.tick_count      = 8'd0;
        out_ch.ready          = 1'b0;

        // reset values of every register
        add_item(ACT_READ, REG_DIV, 8'h00, 8'h00);
        add_item(ACT_READ, REG_CNT, 8'h00, 8'h00);
        add_item(ACT_READ, REG_MOD, 8'h00, 8'h00);
        add_item(ACT_READ, REG_CTRL, 8'h00, 8'h00);
        // control keeps only its low bits; tap on bit 7, enabled
        add_item(ACT_WRITE, REG_MOD, 8'hFF, 8'h00);
        add_item(ACT_WRITE, REG_CTRL, 8'hFF, 8'h00);
        add_item(ACT_READ, REG_CTRL, 8'h00, 8'h00);
        // wrap and age in the same advance, then counter write at irq age
        add_item(ACT_WRITE, REG_CNT, 8'hFF, 8'h00);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'hFF);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h01);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h00);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h00);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h00);
        add_item(ACT_WRITE, REG_CNT, 8'h00, 8'h00);
        // divider clear produces the edge; later counter write must be dropped
        add_item(ACT_WRITE, REG_CNT, 8'hFF, 8'h00);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h80);
        add_item(ACT_WRITE, REG_DIV, 8'hAB, 8'h00);
        for (int k = 0; k < 5; k++)
            add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h00);
        add_item(ACT_WRITE, REG_CNT, 8'h12, 8'h00);
        add_item(ACT_READ, REG_CNT, 8'h00, 8'h00);
        add_item(ACT_ADVANCE, REG_DIV, 8'h00, 8'h00);
        add_item(ACT_UNUSED, REG_CTRL, 8'hFF, 8'hFF);
        add_item(ACT_READ, REG_DIV, 8'h00, 8'h00);

        while (pending_items.size() < N_RANDOM + 27) begin
            if ($urandom_range(0, 99) < 70)
                add_overflow_run();
            else
                repeat ($urandom_range(5, 15)) add_noise_item();
        end
        total_items = pending_items.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_in_count < total_items || exp_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (errors == 0 && exp_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
sv/dtr_pkg.sv
sv/dtr_if.sv
sv/dtr_in_stage.sv
sv/dtr_core.sv
sv/divider_timer_with_reload_top.sv
sv/dtr_checker.sv
test/divider_timer_with_reload_top_tb.sv
